@@ hdl/fwk_pkg.sv @@
// fwk_pkg: shared types and constants for the fenwick range-sum block
// used by fwk_front, fwk_queue, fwk_back and the top level; no dependencies
`timescale 1ns / 1ps

package fwk_pkg;

  localparam int TABLE_SIZE_DEFAULT = 1024;

  // wide enough for an index or an index plus one at any table size in range
  localparam int PTR_W = 17;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [10:0] ACTIVE_SIZE_RESET = 11'd1024;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_QUERY,
    OP_ERROR
  } fwk_op_t;

  typedef struct packed {
    fwk_op_t            op;
    logic [PTR_W-1:0]   first;
    logic [PTR_W-1:0]   last_plus1;
    logic [31:0]        amount;
  } fwk_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ENTRY_RD,
    ST_ENTRY_WR,
    ST_TREE_RD,
    ST_TREE_WR,
    ST_QUERY_RD,
    ST_QUERY_ACC
  } fwk_state_t;

endpackage

@@ hdl/fwk_front.sv @@
// fwk_front: size register, word acceptance and range checks
// turns each accepted word into a command for fwk_queue; uses fwk_pkg
`timescale 1ns / 1ps

module fwk_front #(
  parameter int TABLE_SIZE = fwk_pkg::TABLE_SIZE_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [10:0]       cfg_wdata,
  input  logic              start,
  input  logic [1:0]        mode,
  input  logic [9:0]        first_index,
  input  logic [9:0]        last_index,
  input  logic [31:0]       amount,
  input  logic              q_full,
  input  logic              clearing,
  output logic              busy,
  output logic              push,
  output fwk_pkg::fwk_cmd_t cmd
);
  import fwk_pkg::*;

  localparam int N_W   = $clog2(TABLE_SIZE + 1);
  localparam int CMP_W = (N_W > 11) ? N_W : 11;

  logic [10:0]      active_size;
  logic [CMP_W-1:0] size_ext;
  logic [CMP_W-1:0] n_use;
  logic [CMP_W-1:0] lo;
  logic [CMP_W-1:0] hi;
  logic             lo_bad;
  logic             hi_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= ACTIVE_SIZE_RESET;
    end else if (cfg_we) begin
      active_size <= cfg_wdata;
    end
  end

  // size in use saturates to 1..TABLE_SIZE
  always_comb begin
    size_ext = CMP_W'(active_size);
    if (size_ext == '0) begin
      n_use = CMP_W'(1);
    end else if (size_ext > CMP_W'(TABLE_SIZE)) begin
      n_use = CMP_W'(TABLE_SIZE);
    end else begin
      n_use = size_ext;
    end
  end

  assign lo     = CMP_W'(first_index);
  assign hi     = CMP_W'(last_index);
  assign lo_bad = (lo >= n_use);
  assign hi_bad = (hi >= n_use) || (hi < lo);

  assign busy = q_full || clearing;
  assign push = start && !busy;

  always_comb begin
    cmd.first      = PTR_W'(first_index);
    cmd.last_plus1 = PTR_W'(last_index) + PTR_W'(1);
    cmd.amount     = amount;
    case (mode)
      MODE_ADD: begin
        cmd.op = lo_bad ? OP_ERROR : OP_ADD;
      end
      MODE_REMOVE: begin
        cmd.op = lo_bad ? OP_ERROR : OP_REMOVE;
      end
      MODE_QUERY: begin
        cmd.op = (lo_bad || hi_bad) ? OP_ERROR : OP_QUERY;
      end
      default: begin
        cmd.op = OP_ERROR;
      end
    endcase
  end

endmodule

@@ hdl/fwk_queue.sv @@
// fwk_queue: short command queue between front and back
// decouples acceptance from execution; uses fwk_pkg
`timescale 1ns / 1ps

module fwk_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fwk_pkg::fwk_cmd_t push_cmd,
  input  logic              pop,
  output fwk_pkg::fwk_cmd_t pop_cmd,
  output logic              empty,
  output logic              full
);
  import fwk_pkg::*;

  localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QP_W-1:0] QP_LAST = QP_W'(QUEUE_DEPTH - 1);

  fwk_cmd_t        slots [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QC_W-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign empty   = (count == '0);
  assign full    = (count == QC_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QP_LAST) ? '0 : wr_ptr + QP_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QP_LAST) ? '0 : rd_ptr + QP_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QC_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QC_W'(1);
      end
    end
  end

endmodule

@@ hdl/fwk_back.sv @@
// fwk_back: entry and tree memories, clearing sweep and the tree walks
// executes commands popped from fwk_queue; uses fwk_pkg
`timescale 1ns / 1ps

module fwk_back #(
  parameter int TABLE_SIZE = fwk_pkg::TABLE_SIZE_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  fwk_pkg::fwk_cmd_t q_cmd,
  output logic              pop,
  output logic              clearing,
  output logic              done,
  output logic [63:0]       range_sum,
  output logic [31:0]       removed,
  output logic              error
);
  import fwk_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int K_W   = IDX_W + 1;

  logic [63:0] entry_mem [TABLE_SIZE];
  logic [63:0] tree_mem  [TABLE_SIZE];

  fwk_state_t       state, state_next;
  fwk_cmd_t         cmd, cmd_next;
  logic [K_W-1:0]   k, k_next;
  logic [K_W-1:0]   r;
  logic [63:0]      acc, acc_next;
  logic [63:0]      delta, delta_next;
  logic [31:0]      gone, gone_next;
  logic             phase, phase_next;
  logic [IDX_W-1:0] clr_idx;

  logic             ent_we, tree_we;
  logic [IDX_W-1:0] ent_addr, tree_addr;
  logic [63:0]      ent_wdata, tree_wdata;
  logic [63:0]      ent_rdata, tree_rdata;

  logic             emit;
  logic [63:0]      emit_sum;
  logic [31:0]      emit_removed;
  logic             emit_err;

  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[ent_addr] <= ent_wdata;
    end
    ent_rdata <= entry_mem[ent_addr];
  end

  always_ff @(posedge clk) begin
    if (tree_we) begin
      tree_mem[tree_addr] <= tree_wdata;
    end
    tree_rdata <= tree_mem[tree_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd       <= cmd_next;
    k         <= k_next;
    acc       <= acc_next;
    delta     <= delta_next;
    gone      <= gone_next;
    phase     <= phase_next;
    range_sum <= emit_sum;
    removed   <= emit_removed;
    error     <= emit_err;
  end

  assign clearing = (state == ST_CLEAR);
  assign r        = k - K_W'(1);
  assign ent_addr = (state == ST_CLEAR) ? clr_idx : cmd.first[IDX_W-1:0];

  always_comb begin
    state_next   = state;
    cmd_next     = cmd;
    k_next       = k;
    acc_next     = acc;
    delta_next   = delta;
    gone_next    = gone;
    phase_next   = phase;
    pop          = 1'b0;
    ent_we       = 1'b0;
    ent_wdata    = '0;
    tree_we      = 1'b0;
    tree_wdata   = '0;
    tree_addr    = k[IDX_W-1:0];
    emit         = 1'b0;
    emit_sum     = '0;
    emit_removed = '0;
    emit_err     = 1'b0;

    case (state)
      ST_CLEAR: begin
        // sweep zeros into both memories
        ent_we    = 1'b1;
        tree_we   = 1'b1;
        tree_addr = clr_idx;
        if (clr_idx == IDX_W'(TABLE_SIZE - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          cmd_next = q_cmd;
          case (q_cmd.op)
            OP_ADD, OP_REMOVE: begin
              state_next = ST_ENTRY_RD;
            end
            OP_QUERY: begin
              k_next     = q_cmd.last_plus1[K_W-1:0];
              acc_next   = '0;
              phase_next = 1'b0;
              state_next = ST_QUERY_RD;
            end
            default: begin
              emit     = 1'b1;
              emit_err = 1'b1;
            end
          endcase
        end
      end
      ST_ENTRY_RD: begin
        state_next = ST_ENTRY_WR;
      end
      ST_ENTRY_WR: begin
        ent_we = 1'b1;
        if (cmd.op == OP_REMOVE) begin
          gone_next  = ({32'd0, cmd.amount} < ent_rdata) ? cmd.amount : ent_rdata[31:0];
          ent_wdata  = ent_rdata - {32'd0, gone_next};
          delta_next = 64'd0 - {32'd0, gone_next};
        end else begin
          gone_next  = '0;
          ent_wdata  = ent_rdata + {32'd0, cmd.amount};
          delta_next = {32'd0, cmd.amount};
        end
        k_next     = cmd.first[K_W-1:0];
        state_next = ST_TREE_RD;
      end
      ST_TREE_RD: begin
        state_next = ST_TREE_WR;
      end
      ST_TREE_WR: begin
        tree_we    = 1'b1;
        tree_wdata = tree_rdata + delta;
        k_next     = k | (k + K_W'(1));
        if (k_next >= K_W'(TABLE_SIZE)) begin
          emit         = 1'b1;
          emit_removed = gone;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_TREE_RD;
        end
      end
      ST_QUERY_RD: begin
        tree_addr  = r[IDX_W-1:0];
        state_next = ST_QUERY_ACC;
      end
      ST_QUERY_ACC: begin
        tree_addr = r[IDX_W-1:0];
        acc_next  = phase ? (acc - tree_rdata) : (acc + tree_rdata);
        k_next    = r & (r + K_W'(1));
        state_next = ST_QUERY_RD;
        if (k_next == '0) begin
          if (!phase && (cmd.first[K_W-1:0] != '0)) begin
            // second chain takes away the prefix below the range
            phase_next = 1'b1;
            k_next     = cmd.first[K_W-1:0];
          end else begin
            emit       = 1'b1;
            emit_sum   = acc_next;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/fenwick_point_update_range_sum.sv @@
// fenwick_point_update_range_sum: top level of the fenwick range-sum block
// ties fwk_front, fwk_queue and fwk_back together; uses fwk_pkg
`timescale 1ns / 1ps

//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+---------------------------
//  config    | cfg_we, cfg_wdata (active_size)                | written when cfg_we high
//  command   | mode, first_index, last_index, amount          | taken when start & !busy
//  result    | range_sum, removed, error                      | one cycle, marked by done
//
//  an add or remove reads and writes the entry, then reads and writes each node
//  on the upward chain (at most log2(TABLE_SIZE) + 1 nodes); a query reads and
//  accumulates each node on both prefix chains; an error word is answered from idle.
//  each tree access is split into a read step and a use step, since the single-port tree memory has a registered read.
//  after reset both memories are swept to zero, one entry a cycle, with busy
//  held high until every entry is cleared; config writes are still taken.
//  a two-word queue lets the front accept while the back is still working;
//  the receiver cannot stall, so done is one pulse per word, in order.

module fenwick_point_update_range_sum #(
  parameter int TABLE_SIZE = fwk_pkg::TABLE_SIZE_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // size register
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [9:0]  first_index,
  input  logic [9:0]  last_index,
  input  logic [31:0] amount,
  // result side
  output logic        done,
  output logic [63:0] range_sum,
  output logic [31:0] removed,
  output logic        error
);
  import fwk_pkg::*;

  fwk_cmd_t front_cmd;
  fwk_cmd_t q_cmd;
  logic     push;
  logic     pop;
  logic     q_empty;
  logic     q_full;
  logic     clearing;

  // classify and range-check each word against the size in use
  fwk_front #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .start       (start),
    .mode        (mode),
    .first_index (first_index),
    .last_index  (last_index),
    .amount      (amount),
    .q_full      (q_full),
    .clearing    (clearing),
    .busy        (busy),
    .push        (push),
    .cmd         (front_cmd)
  );

  // holds classified commands until the back is free
  fwk_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .pop_cmd  (q_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  // memories and the fenwick walks; drives the result strobe
  fwk_back #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .clearing  (clearing),
    .done      (done),
    .range_sum (range_sum),
    .removed   (removed),
    .error     (error)
  );

endmodule
